// File: rtl/hkrt_pkg.sv
// Boot-keyboard report tracker: shared types, codes and the modifier decode.
// No dependencies; used by the interfaces, the slot scan unit and the top level.
`timescale 1ns / 1ps

package hkrt_pkg;

  localparam int UsageW   = 8;
  localparam int CodeW    = 10;
  localparam int IndexW   = 8;
  localparam int CodeExtW = CodeW + 1;
  localparam int OutSlots = 6;

  typedef logic [UsageW-1:0] usage_t;

  typedef enum logic {
    OP_KEY_EVENT = 1'b0,
    OP_MAP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // input-layer modifier keycodes
  localparam logic [7:0] KEY_LCTRL  = 8'd29;
  localparam logic [7:0] KEY_LSHIFT = 8'd42;
  localparam logic [7:0] KEY_LALT   = 8'd56;
  localparam logic [7:0] KEY_LMETA  = 8'd125;
  localparam logic [7:0] KEY_RCTRL  = 8'd97;
  localparam logic [7:0] KEY_RSHIFT = 8'd54;
  localparam logic [7:0] KEY_RALT   = 8'd100;
  localparam logic [7:0] KEY_RMETA  = 8'd126;

  typedef struct packed {
    logic                op;
    logic                is_key_event;
    logic [CodeW-1:0]    key_code;
    logic                pressed;
    logic [IndexW-1:0]   map_index;
    usage_t              map_value;
  } in_item_t;

  typedef struct packed {
    usage_t modifier_byte;
    usage_t slot0;
    usage_t slot1;
    usage_t slot2;
    usage_t slot3;
    usage_t slot4;
    usage_t slot5;
  } out_item_t;

  typedef struct packed {
    logic   start;
    logic   press;
    usage_t usage;
  } scan_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_sts_t;

  function automatic logic [7:0] mod_bit(input logic [7:0] code);
    logic [7:0] m;
    m = 8'h00;
    unique case (code)
      KEY_LCTRL:  m = 8'h01;
      KEY_LSHIFT: m = 8'h02;
      KEY_LALT:   m = 8'h04;
      KEY_LMETA:  m = 8'h08;
      KEY_RCTRL:  m = 8'h10;
      KEY_RSHIFT: m = 8'h20;
      KEY_RALT:   m = 8'h40;
      KEY_RMETA:  m = 8'h80;
      default:    m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/hkrt_if.sv
// Valid/ready channel interfaces for the key-event input and the report output.
// Depends on hkrt_pkg for the payload types.
`timescale 1ns / 1ps

interface hkrt_in_if;
  logic               valid;
  logic               ready;
  hkrt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hkrt_out_if;
  logic                valid;
  logic                ready;
  hkrt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/hkrt_slot_scan.sv
// Key slot store and its one-slot-per-cycle scan unit (rotating window).
// Depends on hkrt_pkg.
`timescale 1ns / 1ps

module hkrt_slot_scan #(
  parameter int SLOT_COUNT = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hkrt_pkg::scan_cmd_t cmd,
  output hkrt_pkg::scan_sts_t sts,
  output hkrt_pkg::usage_t    slots [SLOT_COUNT]
);
  import hkrt_pkg::*;

  localparam int StepW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NxtIdx = (SLOT_COUNT > 1) ? 1 : 0;
  localparam logic [StepW-1:0] LastStep = StepW'(SLOT_COUNT - 1);

  usage_t           slots_r [SLOT_COUNT];
  usage_t           slots_nxt [SLOT_COUNT];
  usage_t           usage_r;
  logic             press_r;
  logic             stop_r, stop_nxt;
  logic             busy_r;
  logic [StepW-1:0] step_r;
  usage_t           cur, nxt_v;
  logic             fill;

  // slot 0 of the window is the slot being scanned; the array rotates left
  // each step, so after a full pass over all slots the order is restored
  always_comb begin
    cur   = slots_r[0];
    nxt_v = slots_r[NxtIdx];
    fill  = 1'b0;
    if (!stop_r) begin
      if (cur == usage_r) cur = '0;
      if (press_r && cur == '0) begin
        cur  = usage_r;
        fill = 1'b1;
      end else if (step_r != LastStep && cur == '0) begin
        cur   = nxt_v;
        nxt_v = '0;
      end
    end
    stop_nxt = stop_r | fill;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      slots_nxt[k] = slots_r[(k + 1) % SLOT_COUNT];
    end
    slots_nxt[0]            = nxt_v;
    slots_nxt[SLOT_COUNT-1] = cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      stop_r <= 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) slots_r[k] <= '0;
    end else if (cmd.start) begin
      busy_r  <= 1'b1;
      step_r  <= '0;
      stop_r  <= 1'b0;
      usage_r <= cmd.usage;
      press_r <= cmd.press;
    end else if (busy_r) begin
      slots_r <= slots_nxt;
      stop_r  <= stop_nxt;
      step_r  <= step_r + StepW'(1);
      if (step_r == LastStep) busy_r <= 1'b0;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && (step_r == LastStep);
  assign slots    = slots_r;

endmodule

// File: rtl/hid_keyboard_report_tracker.sv
// Boot-keyboard report tracker top level: key map RAM, modifier byte, sequencer.
// Depends on hkrt_pkg, hkrt_if and hkrt_slot_scan.
//
//   channel | dir | handshake         | beat
//   in_bus  | in  | valid/ready       | key event or key-map write
//   out_bus | out | valid/ready       | modifier byte and six key slots
//
// Map writes and ignored events are taken at the input; the sequencer stays idle.
// A modifier key goes from the accept to the report load.
// A non-modifier key: map read, scan at one slot per cycle, then the report load.
// Reset clears modifiers and slots; the key map is undefined until written.
// A report waiting on out_bus does not block the input; only the final load waits.
`timescale 1ns / 1ps

module hid_keyboard_report_tracker #(
  parameter int SLOT_COUNT  = 6,
  parameter int MAP_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  hkrt_in_if.sink    in_bus,
  hkrt_out_if.source out_bus
);
  import hkrt_pkg::*;

  localparam int AddrW = $clog2(MAP_ENTRIES);
  localparam logic [CodeExtW-1:0] MapLimit = CodeExtW'(MAP_ENTRIES);

  state_t              st_r, st_nxt;
  usage_t              map_mem [MAP_ENTRIES];
  usage_t              map_q_r;
  logic                in_map_r;
  logic                press_r;
  usage_t              held_r;
  logic                out_valid_r;
  out_item_t           out_data_r;
  scan_cmd_t           scan_cmd;
  scan_sts_t           scan_sts;
  usage_t              slots [SLOT_COUNT];
  usage_t              rpt_slots [OutSlots];
  logic                in_fire, emit_load;
  logic [CodeExtW-1:0] code_ext, idx_ext;
  logic                code_ok, key_fire, wr_fire;
  logic [7:0]          mod;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign code_ext = {1'b0, in_bus.data.key_code};
  assign idx_ext  = {{(CodeExtW-IndexW){1'b0}}, in_bus.data.map_index};
  assign code_ok  = in_bus.data.is_key_event && (in_bus.data.key_code[CodeW-1:IndexW] == '0);
  assign mod      = mod_bit(in_bus.data.key_code[7:0]);
  assign key_fire = in_fire && (in_bus.data.op == OP_KEY_EVENT) && code_ok;
  assign wr_fire  = in_fire && (in_bus.data.op == OP_MAP_WRITE) && (idx_ext < MapLimit);

  // key map RAM
  always_ff @(posedge clk) begin
    if (wr_fire) map_mem[idx_ext[AddrW-1:0]] <= in_bus.data.map_value;
    if (key_fire) map_q_r <= map_mem[code_ext[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (key_fire) begin
      in_map_r <= code_ext < MapLimit;
      press_r  <= in_bus.data.pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (key_fire && mod != '0) begin
      held_r <= in_bus.data.pressed ? (held_r | mod) : (held_r & ~mod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt         = st_r;
    in_bus.ready   = 1'b0;
    emit_load      = 1'b0;
    scan_cmd.start = 1'b0;
    scan_cmd.press = press_r;
    scan_cmd.usage = in_map_r ? map_q_r : '0;
    unique case (st_r)
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (key_fire) st_nxt = (mod != '0) ? ST_EMIT : ST_LOOKUP;
      end
      ST_LOOKUP: begin
        scan_cmd.start = 1'b1;
        st_nxt         = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_sts.done) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_bus.ready) begin
          emit_load = 1'b1;
          st_nxt    = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  hkrt_slot_scan #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (scan_cmd),
    .sts  (scan_sts),
    .slots(slots)
  );

  for (genvar k = 0; k < OutSlots; k++) begin : g_rpt
    if (k < SLOT_COUNT) begin : g_on
      assign rpt_slots[k] = slots[k];
    end else begin : g_off
      assign rpt_slots[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r.modifier_byte <= held_r;
      out_data_r.slot0         <= rpt_slots[0];
      out_data_r.slot1         <= rpt_slots[1];
      out_data_r.slot2         <= rpt_slots[2];
      out_data_r.slot3         <= rpt_slots[3];
      out_data_r.slot4         <= rpt_slots[4];
      out_data_r.slot5         <= rpt_slots[5];
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> !scan_sts.busy)
    else $error("scan unit busy while sequencer idle");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_sts.done |-> st_r == ST_SCAN)
    else $error("scan done outside scan state");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> out_valid_r)
    else $error("report load did not raise out valid");

  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_bus.data.op == OP_MAP_WRITE |=> st_r == ST_IDLE && !emit_load)
    else $error("map write started report work");

endmodule
